[hdl/multiset_intersection_sorted_core_assert.svh]
// Assertion macros used by the multiset intersection sequencer.
`ifndef MULTISET_INTERSECTION_SORTED_CORE_ASSERT_SVH
`define MULTISET_INTERSECTION_SORTED_CORE_ASSERT_SVH

// Same-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define MSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define MSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/msi_pkg.sv]
// Package with the types and constants of the multiset intersection block.
`default_nettype none

package msi_pkg;

    localparam int VALUE_RANGE = 1024;
    localparam int COUNT_BITS  = 16;
    localparam int VALUE_BITS  = 10;
    localparam int ADDR_BITS   = (VALUE_RANGE > 2) ? $clog2(VALUE_RANGE) : 1;
    localparam int CURSOR_BITS = ADDR_BITS + 1;

    typedef logic [1:0]             t_req;
    typedef logic [VALUE_BITS-1:0]  t_value;
    typedef logic [ADDR_BITS-1:0]   t_addr;
    typedef logic [CURSOR_BITS-1:0] t_cursor;
    typedef logic [COUNT_BITS-1:0]  t_count;

    localparam t_req REQ_LOAD  = 2'd0;
    localparam t_req REQ_PROBE = 2'd1;
    localparam t_req REQ_FETCH = 2'd2;
    localparam t_req REQ_CLEAR = 2'd3;

    localparam t_addr   ADDR_LAST  = t_addr'(VALUE_RANGE - 1);
    localparam t_cursor CURSOR_END = t_cursor'(VALUE_RANGE);
    localparam t_count  COUNT_MAX  = '1;

    // One table entry: unmatched first-list copies and matched copies.
    typedef struct packed {
        t_count remaining;
        t_count matched;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_entry data;
    } t_wr_port;

    typedef struct packed {
        logic   valid;
        t_value value;
        logic   found;
    } t_result;

endpackage

`default_nettype wire

[hdl/msi_table.sv]
// Count table: one write port and one registered read port.
`default_nettype none

module msi_table (
    input  wire logic              i_clk,
    input  wire msi_pkg::t_wr_port i_wr,
    input  wire msi_pkg::t_addr    i_rd_addr,
    output msi_pkg::t_entry        o_rd_data
);
    import msi_pkg::*;

    t_entry mem [VALUE_RANGE];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/msi_seq.sv]
// Sequencer: clearing sweep, read-modify-write of counts and the ordered fetch walk.
`default_nettype none

module msi_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire msi_pkg::t_req     i_req_type,
    input  wire msi_pkg::t_value   i_value,
    output msi_pkg::t_result       o_res,
    input  wire logic              i_res_ready,
    output msi_pkg::t_wr_port      o_wr,
    output msi_pkg::t_addr         o_rd_addr,
    input  wire msi_pkg::t_entry   i_rd_data
);
    import msi_pkg::*;

    `include "multiset_intersection_sorted_core_assert.svh"

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RMW  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    t_addr      r_addr, n_addr;
    t_cursor    r_cursor, n_cursor;
    t_req       r_req, n_req;
    t_value     r_res_value, n_res_value;
    logic       r_res_found, n_res_found;

    logic   in_range;
    t_addr  in_addr;
    t_entry upd_load;
    t_entry upd_probe;

    assign in_range = (32'(i_value) < 32'(VALUE_RANGE));
    assign in_addr  = t_addr'(i_value);

    // Saturating updates of the entry that was just read.
    always_comb begin
        upd_load  = i_rd_data;
        upd_probe = i_rd_data;
        if (i_rd_data.remaining != COUNT_MAX) begin
            upd_load.remaining = i_rd_data.remaining + t_count'(1);
        end
        if (i_rd_data.remaining != '0) begin
            upd_probe.remaining = i_rd_data.remaining - t_count'(1);
            if (i_rd_data.matched != COUNT_MAX) begin
                upd_probe.matched = i_rd_data.matched + t_count'(1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cursor    = r_cursor;
        n_req       = r_req;
        n_res_value = r_res_value;
        n_res_found = r_res_found;
        o_in_ready  = 1'b0;
        o_rd_addr   = r_addr;
        o_wr        = '{en: 1'b0, addr: r_addr, data: i_rd_data};
        o_res       = '{valid: 1'b0, value: r_res_value, found: r_res_found};

        unique case (r_state)
            S_CLR: begin
                o_wr.en   = 1'b1;
                o_wr.data = '0;
                if (r_addr == ADDR_LAST) begin
                    n_state  = S_IDLE;
                    n_cursor = '0;
                end else begin
                    n_addr = r_addr + t_addr'(1);
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_req_type == REQ_FETCH) begin
                    o_rd_addr = r_cursor[ADDR_BITS-1:0];
                end else begin
                    o_rd_addr = in_addr;
                end
                // Ready is high throughout this state, so valid alone accepts.
                if (i_in_valid) begin
                    unique case (i_req_type)
                        REQ_LOAD, REQ_PROBE: begin
                            if (in_range) begin
                                n_addr  = in_addr;
                                n_req   = i_req_type;
                                n_state = S_RMW;
                            end
                        end
                        REQ_FETCH: begin
                            if (r_cursor == CURSOR_END) begin
                                n_res_value = '0;
                                n_res_found = 1'b0;
                                n_state     = S_DONE;
                            end else begin
                                n_addr  = r_cursor[ADDR_BITS-1:0];
                                n_state = S_WALK;
                            end
                        end
                        REQ_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RMW: begin
                o_wr.en   = 1'b1;
                o_wr.data = (r_req == REQ_LOAD) ? upd_load : upd_probe;
                n_state   = S_IDLE;
            end
            S_WALK: begin
                // The read for the following address is issued every cycle; it is
                // simply dropped when the walk stops here.
                o_rd_addr = r_addr + t_addr'(1);
                if (i_rd_data.matched != '0) begin
                    o_wr.en           = 1'b1;
                    o_wr.data.matched = i_rd_data.matched - t_count'(1);
                    n_cursor          = t_cursor'(r_addr);
                    n_res_value       = t_value'(r_addr);
                    n_res_found       = 1'b1;
                    n_state           = S_DONE;
                end else if (r_addr == ADDR_LAST) begin
                    n_cursor    = CURSOR_END;
                    n_res_value = '0;
                    n_res_found = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    n_addr = r_addr + t_addr'(1);
                end
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_addr   <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_res_value <= n_res_value;
        r_res_found <= n_res_found;
    end

    `MSI_ASSERT_NOW(a_wr_state, o_wr.en,
        (r_state == S_CLR) || (r_state == S_RMW) || (r_state == S_WALK),
        "table written outside a clearing, update or walk cycle")
    `MSI_ASSERT_NEXT(a_walk_hit, (r_state == S_WALK) && o_wr.en,
        (r_state == S_DONE) && r_res_found && (r_cursor < CURSOR_END),
        "walk hit did not produce a found result")
    `MSI_ASSERT_NEXT(a_clr_end, (r_state == S_CLR) && (r_addr == ADDR_LAST),
        (r_state == S_IDLE) && (r_cursor == '0),
        "clearing sweep did not end idle with the cursor at zero")
    `MSI_ASSERT_NOW(a_cursor_range, 1'b1, r_cursor <= CURSOR_END,
        "fetch cursor beyond the table end")

endmodule

`default_nettype wire

[hdl/multiset_intersection_sorted_core.sv]
// Top level of the counting multiset intersection block.
//
// Input channel (i_in_valid / o_in_ready) carries one request item: a load
// adds a first-list value, a probe matches a second-list value, a fetch asks
// for the next common value in ascending order, and a clear empties the block.
// Only a fetch produces a result item on the output channel
// (o_out_valid / i_out_ready): the value and a found flag that is low once no
// matched copy is left at or above the fetch cursor.
// A load or probe does one table read, then the write back.
// A fetch walks the table upward from the cursor, at most to the table end;
// the walk reads one entry per cycle through the single read port, and its
// result is then offered to the output register.
// A clear writes zero to every table entry in turn.
// After reset the same clearing sweep runs and o_in_ready stays low until
// it ends. A result waits in the output register while the receiver
// stalls; the block keeps taking loads and probes meanwhile and only holds
// the end of the next fetch until the output register is free again.
`default_nettype none

module multiset_intersection_sorted_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire msi_pkg::t_req   i_req_type,
    input  wire msi_pkg::t_value i_value,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output msi_pkg::t_value      o_common_value,
    output logic                 o_found
);
    import msi_pkg::*;

    t_wr_port wr;
    t_addr    rd_addr;
    t_entry   rd_data;
    t_result  res;
    logic     res_ready;

    logic   r_out_valid;
    t_value r_out_value;
    logic   r_out_found;

    // The sequencer owns the table and walks it for fetches.
    msi_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // Both per-value counts share one word of the table.
    msi_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: takes a new result when empty or being drained.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_value <= res.value;
            r_out_found <= res.found;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_common_value = r_out_value;
    assign o_found        = r_out_found;

endmodule

`default_nettype wire
